[hdl/mwlm_pkg.sv]
// shared types and constants for the multichannel window limit monitor
// no dependencies; every other file of the block except mwlm_ram refers to this package by scoped names
package mwlm_pkg;

	// parameter defaults
	localparam int MAX_CHANNELS_DEF = 16;
	localparam int WINDOW_ROWS_DEF  = 5;
	localparam int SAMPLE_BITS_DEF  = 16;

	// fixed field widths
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int ROW_W     = 24;
	localparam int CNT_W     = 5;

	localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_W-1:0] THRESHOLD_RESET = 5'd0;
	localparam logic [CFG_W-1:0] ACTIVE_RESET    = 5'd16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 1'b1;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LIMITS = 1'b1;

	// row bookkeeping that travels with a sample down the pipeline
	typedef struct packed {
		logic             last;
		logic             emit;
		logic [ROW_W-1:0] row_number;
	} row_tag_t;

endpackage

[hdl/multichannel_window_limit_monitor.sv]
// top level of the multichannel window limit monitor: history, sum and limit memories
// and the read-modify-write pipeline; depends on mwlm_pkg, mwlm_ram, mwlm_ctrl, mwlm_check
//
//   port group   direction  flow control        payload
//   in_*         input      in_valid/in_stall   req_type, channel, sample, low_limit, high_limit
//   out_*        output     out_valid/out_stall row_number, failing_count, row_anomalous
//   cfg_*        input      cfg_we              cfg_index, cfg_data
//
// one item per cycle while in_stall is low; the sample that ends a row passes the stage 1 and
// stage 2 registers before the output register loads (memory read, sum update and write-back, compare)
// the memories read and write on separate ports in the same cycle; a sample that hits
// the entry written by the sample just ahead of it takes the forwarded value, so no bubble is needed
// reset clears valid bits for every history and sum entry at once, with no clearing pass
// a stalled result holds the whole pipeline; in_stall is high while a result waits on out_stall
module multichannel_window_limit_monitor #(
	parameter int MAX_CHANNELS = mwlm_pkg::MAX_CHANNELS_DEF,
	parameter int WINDOW_ROWS  = mwlm_pkg::WINDOW_ROWS_DEF,
	parameter int SAMPLE_BITS  = mwlm_pkg::SAMPLE_BITS_DEF,
	parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mwlm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mwlm_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [CH_W-1:0]                   channel,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic signed [SAMPLE_BITS-1:0]     low_limit,
	input  logic signed [SAMPLE_BITS-1:0]     high_limit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mwlm_pkg::ROW_W-1:0]        row_number,
	output logic [mwlm_pkg::CNT_W-1:0]        failing_count,
	output logic                              row_anomalous
);

	localparam int HIST_DEPTH = WINDOW_ROWS * MAX_CHANNELS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_ROWS);

	logic                       en;
	logic                       accept;
	logic                       sample_go;
	logic                       limit_we;
	logic [HIST_AW-1:0]         hist_addr;
	mwlm_pkg::row_tag_t         tag;
	logic [mwlm_pkg::CFG_W-1:0] threshold;

	// stage 1: memory read data arrives
	logic                          valid_s1;
	logic [CH_W-1:0]               ch_s1;
	logic [HIST_AW-1:0]            hidx_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	mwlm_pkg::row_tag_t            tag_s1;

	// stage 2: last write-back, kept for forwarding and the compare
	logic                          valid_s2;
	logic [CH_W-1:0]               ch_s2;
	logic [HIST_AW-1:0]            hidx_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic signed [SUM_W-1:0]       sum_s2;
	logic signed [SAMPLE_BITS-1:0] low_s2;
	logic signed [SAMPLE_BITS-1:0] high_s2;
	mwlm_pkg::row_tag_t            tag_s2;

	logic [HIST_DEPTH-1:0]   hist_vld_q;
	logic [MAX_CHANNELS-1:0] sum_vld_q;

	logic [SAMPLE_BITS-1:0]        hist_rdata;
	logic [SUM_W-1:0]              sum_rdata;
	logic [2*SAMPLE_BITS-1:0]      lim_rdata;
	logic signed [SAMPLE_BITS-1:0] old_sample;
	logic signed [SUM_W-1:0]       old_sum;
	logic signed [SUM_W-1:0]       new_sum;
	logic                          wb;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	mwlm_ctrl #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.WINDOW_ROWS  (WINDOW_ROWS),
		.CH_W         (CH_W),
		.HIST_AW      (HIST_AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.req_type  (req_type),
		.channel   (channel),
		.sample_go (sample_go),
		.limit_we  (limit_we),
		.hist_addr (hist_addr),
		.tag       (tag),
		.threshold (threshold)
	);

	mwlm_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (wb),
		.waddr (hidx_s1),
		.wdata (sample_s1),
		.re    (en),
		.raddr (hist_addr),
		.rdata (hist_rdata)
	);

	mwlm_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_CHANNELS)
	) u_sum_ram (
		.clk   (clk),
		.we    (wb),
		.waddr (ch_s1),
		.wdata (new_sum),
		.re    (en),
		.raddr (channel),
		.rdata (sum_rdata)
	);

	mwlm_ram #(
		.WIDTH (2 * SAMPLE_BITS),
		.DEPTH (MAX_CHANNELS)
	) u_limit_ram (
		.clk   (clk),
		.we    (limit_we),
		.waddr (channel),
		.wdata ({high_limit, low_limit}),
		.re    (en),
		.raddr (channel),
		.rdata (lim_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample_go;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1     <= channel;
			hidx_s1   <= hist_addr;
			sample_s1 <= sample;
			tag_s1    <= tag;
			ch_s2     <= ch_s1;
			hidx_s2   <= hidx_s1;
			sample_s2 <= sample_s1;
			sum_s2    <= new_sum;
			low_s2    <= lim_rdata[SAMPLE_BITS-1:0];
			high_s2   <= lim_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			tag_s2    <= tag_s1;
		end
	end

	// the entry written on the edge that loaded stage 1 is read stale, take it from stage 2
	always_comb begin
		if (valid_s2 && (hidx_s2 == hidx_s1)) begin
			old_sample = sample_s2;
		end else if (hist_vld_q[hidx_s1]) begin
			old_sample = hist_rdata;
		end else begin
			old_sample = '0;
		end
		if (valid_s2 && (ch_s2 == ch_s1)) begin
			old_sum = sum_s2;
		end else if (sum_vld_q[ch_s1]) begin
			old_sum = sum_rdata;
		end else begin
			old_sum = '0;
		end
		new_sum = old_sum - SUM_W'(old_sample) + SUM_W'(sample_s1);
		wb      = en && valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			sum_vld_q  <= '0;
		end else if (wb) begin
			hist_vld_q[hidx_s1] <= 1'b1;
			sum_vld_q[ch_s1]    <= 1'b1;
		end
	end

	mwlm_check #(
		.WINDOW_ROWS (WINDOW_ROWS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.valid_s2      (valid_s2),
		.tag_s2        (tag_s2),
		.sum_s2        (sum_s2),
		.low_s2        (low_s2),
		.high_s2       (high_s2),
		.threshold     (threshold),
		.out_valid     (out_valid),
		.row_number    (row_number),
		.failing_count (failing_count),
		.row_anomalous (row_anomalous)
	);

	// no result before the window has filled
	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (row_number >= mwlm_pkg::ROW_W'(WINDOW_ROWS)))
		else $error("result before window filled");

	// a result that follows a transfer carries a later row unless the counter saturated
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=>
		(!out_valid || (row_number > $past(row_number)) || (row_number == mwlm_pkg::ROW_MAX)))
		else $error("row number did not advance");

	// a write-back marks its history entry as holding data
	a_hist_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wb |=> hist_vld_q[$past(hidx_s1)])
		else $error("history valid bit not set");

endmodule

[hdl/mwlm_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module mwlm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/mwlm_ctrl.sv]
// configuration registers and row bookkeeping at the input stage
// depends on mwlm_pkg
module mwlm_ctrl #(
	parameter int MAX_CHANNELS = mwlm_pkg::MAX_CHANNELS_DEF,
	parameter int WINDOW_ROWS  = mwlm_pkg::WINDOW_ROWS_DEF,
	parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
	parameter int HIST_AW      = $clog2(WINDOW_ROWS * MAX_CHANNELS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mwlm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwlm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          accept,
	input  logic                          req_type,
	input  logic [CH_W-1:0]               channel,
	output logic                          sample_go,
	output logic                          limit_we,
	output logic [HIST_AW-1:0]            hist_addr,
	output mwlm_pkg::row_tag_t            tag,
	output logic [mwlm_pkg::CFG_W-1:0]    threshold
);

	localparam int CMP_W  = (mwlm_pkg::CFG_W > CH_W + 1) ? mwlm_pkg::CFG_W : CH_W + 1;
	localparam int SLOT_W = $clog2(WINDOW_ROWS);
	localparam int FILL_W = $clog2(WINDOW_ROWS + 1);

	logic [mwlm_pkg::CFG_W-1:0] thr_q;
	logic [mwlm_pkg::CFG_W-1:0] act_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [HIST_AW-1:0]         base_q;
	logic [FILL_W-1:0]          fill_q;
	logic [mwlm_pkg::ROW_W-1:0] row_q;

	logic [CMP_W-1:0]           act_raw;
	logic [CMP_W-1:0]           act_eff;
	logic [CMP_W-1:0]           ch_ext;
	logic                       is_sample;
	logic                       row_end;
	logic [FILL_W-1:0]          fill_next;
	logic [mwlm_pkg::ROW_W-1:0] row_next;

	always_comb begin
		act_raw = CMP_W'(act_q);
		// out-of-range channel counts clamp into 1..MAX_CHANNELS
		if (act_raw == '0) begin
			act_eff = CMP_W'(1);
		end else if (act_raw > CMP_W'(MAX_CHANNELS)) begin
			act_eff = CMP_W'(MAX_CHANNELS);
		end else begin
			act_eff = act_raw;
		end
		ch_ext    = CMP_W'(channel);
		is_sample = (req_type == mwlm_pkg::REQ_SAMPLE);
		sample_go = accept && is_sample && (ch_ext < act_eff);
		limit_we  = accept && !is_sample && (ch_ext < CMP_W'(MAX_CHANNELS));
		row_end   = (ch_ext == act_eff - CMP_W'(1));
		fill_next = (fill_q == FILL_W'(WINDOW_ROWS)) ? fill_q : fill_q + FILL_W'(1);
		row_next  = (row_q == mwlm_pkg::ROW_MAX) ? row_q : row_q + mwlm_pkg::ROW_W'(1);
	end

	assign hist_addr      = base_q + HIST_AW'(channel);
	assign tag.last       = row_end;
	assign tag.emit       = (fill_next == FILL_W'(WINDOW_ROWS));
	assign tag.row_number = row_next;
	assign threshold      = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mwlm_pkg::THRESHOLD_RESET;
			act_q <= mwlm_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mwlm_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				mwlm_pkg::REG_ACTIVE:    act_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot advances at the last active channel of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			base_q <= '0;
			fill_q <= '0;
			row_q  <= '0;
		end else if (sample_go && row_end) begin
			if (slot_q == SLOT_W'(WINDOW_ROWS - 1)) begin
				slot_q <= '0;
				base_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
				base_q <= base_q + HIST_AW'(MAX_CHANNELS);
			end
			fill_q <= fill_next;
			row_q  <= row_next;
		end
	end

endmodule

[hdl/mwlm_check.sv]
// limit compare, failing-channel count and output register
// depends on mwlm_pkg
module mwlm_check #(
	parameter int WINDOW_ROWS = mwlm_pkg::WINDOW_ROWS_DEF,
	parameter int SAMPLE_BITS = mwlm_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_ROWS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_s2,
	input  mwlm_pkg::row_tag_t                tag_s2,
	input  logic signed [SUM_W-1:0]           sum_s2,
	input  logic signed [SAMPLE_BITS-1:0]     low_s2,
	input  logic signed [SAMPLE_BITS-1:0]     high_s2,
	input  logic [mwlm_pkg::CFG_W-1:0]        threshold,
	output logic                              out_valid,
	output logic [mwlm_pkg::ROW_W-1:0]        row_number,
	output logic [mwlm_pkg::CNT_W-1:0]        failing_count,
	output logic                              row_anomalous
);

	localparam logic signed [SUM_W-1:0] WIN_C = SUM_W'(WINDOW_ROWS);

	logic [mwlm_pkg::CNT_W-1:0] fail_q;
	logic                       out_valid_q;

	logic signed [SUM_W-1:0]    low_ext;
	logic signed [SUM_W-1:0]    high_ext;
	logic signed [SUM_W-1:0]    lo_bound;
	logic signed [SUM_W-1:0]    hi_bound;
	logic                       fail;
	logic [mwlm_pkg::CNT_W-1:0] cnt;
	logic                       load;

	// window average inside the open interval, scaled by the window length
	always_comb begin
		low_ext  = SUM_W'(low_s2);
		high_ext = SUM_W'(high_s2);
		lo_bound = low_ext * WIN_C;
		hi_bound = high_ext * WIN_C;
		fail     = !((lo_bound < sum_s2) && (sum_s2 < hi_bound));
		cnt      = (fail && (fail_q != mwlm_pkg::CNT_MAX))
		           ? fail_q + mwlm_pkg::CNT_W'(1) : fail_q;
		load     = en && valid_s2 && tag_s2.last && tag_s2.emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= '0;
		end else if (en && valid_s2) begin
			fail_q <= tag_s2.last ? '0 : cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (en) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_number    <= tag_s2.row_number;
			failing_count <= cnt;
			row_anomalous <= (cnt > threshold);
		end
	end

	assign out_valid = out_valid_q;

endmodule
